// ===== design/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types and constants of the 3x3 box filter with frame maximum.
// ----------------------------------------------------------------------------
package bfm_pkg;

    localparam int ROWS = 64;
    localparam int COLS = 64;

    // Counter widths: wide enough for the frame, never below the 6-bit fields
    localparam int ROW_BITS = ($clog2(ROWS) > 6) ? $clog2(ROWS) : 6;
    localparam int COL_BITS = ($clog2(COLS) > 6) ? $clog2(COLS) : 6;
    localparam int ADDR_W   = $clog2(COLS);

    localparam int PIX_W  = 16;
    localparam int PSUM_W = PIX_W + 2;   // three samples of one row
    localparam int SUM_W  = PIX_W + 4;   // nine samples
    localparam int MEAN_W = 20;
    localparam int X_W    = SUM_W + 4;   // sum in 20.4 fixed point
    localparam int MUL_W  = 24;
    localparam int PROD_W = X_W + MUL_W;

    // floor(x / 9) = (x * DIV_MULT) >> DIV_SHIFT for every x below 2**27
    localparam int          DIV_SHIFT = 27;
    localparam logic [MUL_W-1:0] DIV_MULT = 24'd14913081;

    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_start;
    } t_in;

    typedef struct packed {
        logic [5:0]  center_row;
        logic [5:0]  center_col;
        logic [19:0] mean_value;
        logic [19:0] frame_max;
        logic        frame_done;
    } t_out;

    // Per-item control tag that travels down the pipeline
    typedef struct packed {
        logic       emit;
        logic       clr_before;
        logic       last;
        logic [5:0] row;
        logic [5:0] col;
    } t_tag;

endpackage

// ===== design/bfm_linebuf.sv =====
// ----------------------------------------------------------------------------
// bfm_linebuf
// Two line buffers: the row above and the row two above, registered reads.
// ----------------------------------------------------------------------------
module bfm_linebuf (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [bfm_pkg::ADDR_W-1:0]  i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [bfm_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [bfm_pkg::PIX_W-1:0]   i_wr_pixel,
    input  logic [bfm_pkg::PIX_W-1:0]   i_wr_mid,
    output logic [bfm_pkg::PIX_W-1:0]   o_top,
    output logic [bfm_pkg::PIX_W-1:0]   o_mid
);
    import bfm_pkg::*;

    logic [PIX_W-1:0] r_above     [COLS];
    logic [PIX_W-1:0] r_two_above [COLS];
    logic [PIX_W-1:0] r_top;
    logic [PIX_W-1:0] r_mid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_above[i_wr_addr]     <= i_wr_pixel;
            r_two_above[i_wr_addr] <= i_wr_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_top <= r_two_above[i_rd_addr];
            r_mid <= r_above[i_rd_addr];
        end
    end

    assign o_top = r_top;
    assign o_mid = r_mid;

endmodule

// ===== design/bfm_cell.sv =====
// ----------------------------------------------------------------------------
// bfm_cell
// One window row: holds the two previous columns, sums them with the new one.
// ----------------------------------------------------------------------------
module bfm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [bfm_pkg::PIX_W-1:0]   i_sample,
    output logic [bfm_pkg::PSUM_W-1:0]  o_psum
);
    import bfm_pkg::*;

    logic [PIX_W-1:0]  r_tap_a;   // column col-2
    logic [PIX_W-1:0]  r_tap_b;   // column col-1
    logic [PSUM_W-1:0] r_psum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_a <= '0;
            r_tap_b <= '0;
        end else if (i_en) begin
            r_tap_a <= r_tap_b;
            r_tap_b <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_psum <= PSUM_W'(r_tap_a) + PSUM_W'(r_tap_b) + PSUM_W'(i_sample);
        end
    end

    assign o_psum = r_psum;

endmodule

// ===== design/box_filter_3x3_with_max.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_with_max
// 3x3 box mean over a raster pixel stream with the running frame maximum.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+---------------------------------
//   input    | in        | i_valid / o_stall | i_data : pixel, frame_start
//   output   | out       | o_valid / i_stall | o_data : row, col, mean, max, done
//
// One pixel item is taken every clock while the output is not stalled; the
// pipeline is five stages deep (line buffer read, window cells, sum,
// multiply by 1/9, max and output register).
// Reset (i_rst_n low, synchronous) clears counters, window, stage valids
// and the maximum; the line buffers are not cleared.
// A stalled output item holds the whole pipeline; o_stall rises with it.
// ----------------------------------------------------------------------------
module box_filter_3x3_with_max (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bfm_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output bfm_pkg::t_out  o_data
);
    import bfm_pkg::*;

    // pipeline advance: output register empty or being taken
    logic en;
    logic accept;

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;
    assign accept  = i_valid && en;

    // ---------------------------------------------------------------- stage 0
    // Position of this pixel; a frame-start mark forces (0, 0).
    logic [ROW_BITS-1:0] r_row;
    logic [COL_BITS-1:0] r_col;
    logic [ROW_BITS-1:0] cur_row;
    logic [COL_BITS-1:0] cur_col;
    logic                last_col;
    logic                last_row;
    t_tag                tag0;

    assign cur_row  = i_data.frame_start ? '0 : r_row;
    assign cur_col  = i_data.frame_start ? '0 : r_col;
    assign last_col = (cur_col == COL_BITS'(COLS - 1));
    assign last_row = (cur_row == ROW_BITS'(ROWS - 1));

    always_comb begin
        tag0.emit       = (cur_row >= ROW_BITS'(2)) && (cur_col >= COL_BITS'(2));
        tag0.clr_before = i_data.frame_start;
        tag0.last       = last_row && last_col;
        tag0.row        = 6'(cur_row - ROW_BITS'(1));
        tag0.col        = 6'(cur_col - COL_BITS'(1));
    end

    // advance the counters, wrap at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : cur_row + ROW_BITS'(1);
            end else begin
                r_col <= cur_col + COL_BITS'(1);
                r_row <= cur_row;
            end
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Line buffer data arrives here; the write of this column happens when
    // the item leaves, before or with any later read of the same column.
    logic                r_v1;
    t_tag                r_tag1;
    logic [PIX_W-1:0]    r_px1;
    logic [ADDR_W-1:0]   r_addr1;
    logic [PIX_W-1:0]    top;
    logic [PIX_W-1:0]    mid;
    logic                adv1;

    assign adv1 = r_v1 && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag1  <= tag0;
            r_px1   <= i_data.pixel;
            r_addr1 <= cur_col[ADDR_W-1:0];
        end
    end

    bfm_linebuf u_linebuf (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr  (cur_col[ADDR_W-1:0]),
        .i_wr_en    (adv1),
        .i_wr_addr  (r_addr1),
        .i_wr_pixel (r_px1),
        .i_wr_mid   (mid),
        .o_top      (top),
        .o_mid      (mid)
    );

    // ---------------------------------------------------------------- stage 2
    // Window cells, one per row: top, middle, current.
    logic [PIX_W-1:0]  cell_in  [3];
    logic [PSUM_W-1:0] psum     [3];

    assign cell_in[0] = top;
    assign cell_in[1] = mid;
    assign cell_in[2] = r_px1;

    for (genvar g = 0; g < 3; g++) begin : g_cell
        bfm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (adv1),
            .i_sample (cell_in[g]),
            .o_psum   (psum[g])
        );
    end

    logic r_v2;
    t_tag r_tag2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_tag2 <= r_tag1;
        end
    end

    // ---------------------------------------------------------------- stage 3
    // Full window sum.
    logic             r_v3;
    t_tag             r_tag3;
    logic [SUM_W-1:0] r_sum3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && en) begin
            r_tag3 <= r_tag2;
            r_sum3 <= SUM_W'(psum[0]) + SUM_W'(psum[1]) + SUM_W'(psum[2]);
        end
    end

    // ---------------------------------------------------------------- stage 4
    // Scale the sum to 20.4 and multiply by the reciprocal of nine (16.4 mean).
    logic              r_v4;
    t_tag              r_tag4;
    logic [PROD_W-1:0] r_prod4;
    logic [X_W-1:0]    sum_fx;

    assign sum_fx = {r_sum3, 4'b0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && en) begin
            r_tag4  <= r_tag3;
            r_prod4 <= PROD_W'(sum_fx) * PROD_W'(DIV_MULT);
        end
    end

    // --------------------------------------------------------- max and output
    logic [MEAN_W-1:0] mean;
    logic [MEAN_W-1:0] r_max;
    logic [MEAN_W-1:0] max_base;
    logic [MEAN_W-1:0] max_new;
    logic              r_out_valid;
    t_out              r_out;

    assign mean     = r_prod4[DIV_SHIFT +: MEAN_W];
    assign max_base = r_tag4.clr_before ? '0 : r_max;
    assign max_new  = (r_tag4.emit && (mean > max_base)) ? mean : max_base;

    // drop the maximum at frame start and after the last pixel of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (r_v4 && en) begin
            r_max <= r_tag4.last ? '0 : max_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v4 && r_tag4.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4 && en) begin
            r_out.center_row <= r_tag4.row;
            r_out.center_col <= r_tag4.col;
            r_out.mean_value <= mean;
            r_out.frame_max  <= max_new;
            r_out.frame_done <= r_tag4.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
